>>> hdl/vfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_pkg: shared types and constants of the vector fixed-point ALU
// Word and fraction widths, opcodes, status codes and the saturation helper.
// ----------------------------------------------------------------------------
package vfa_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    localparam int PROD_W     = 2 * WORD_W;
    localparam int EXT_W      = 2 * WORD_W + 1;
    localparam int NUM_W      = WORD_W + FRAC_W;
    localparam int SQ_STAGES  = WORD_W;
    localparam int DIV_STAGES = NUM_W;
    localparam int LANE_DLY   = SQ_STAGES - 1;
    localparam int CTL_DLY    = SQ_STAGES + 2;

    localparam logic [EXT_W-1:0]  NEG_LIM  = EXT_W'(1) << (WORD_W - 1);
    localparam logic [EXT_W-1:0]  POS_LIM  = NEG_LIM - EXT_W'(1);
    localparam logic [WORD_W-1:0] MAX_WORD = {1'b0, {(WORD_W-1){1'b1}}};

    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SCALE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CROSS = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LEN   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NORM  = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
    localparam logic [STAT_W-1:0] ST_DZ  = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT = 2'd2;

    typedef struct packed {
        logic              flag;
        logic [WORD_W-1:0] val;
    } sat_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] a_self;
        logic [WORD_W-1:0] b_self;
        logic [WORD_W-1:0] a_j;
        logic [WORD_W-1:0] a_k;
        logic [WORD_W-1:0] b_j;
        logic [WORD_W-1:0] b_k;
        logic [WORD_W-1:0] s;
    } lane_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] den;
        logic              den_neg;
    } den_t;

    typedef struct packed {
        sat_t elem;
        sat_t quot;
    } lane_out_t;

    // sign/magnitude to saturated two's complement word
    function automatic sat_t sat_sm(input logic neg, input logic [EXT_W-1:0] mag);
        sat_t r;
        r.flag = 1'b0;
        r.val  = '0;
        if (!neg)
        begin
            if (mag > POS_LIM)
            begin
                r.flag = 1'b1;
                r.val  = MAX_WORD;
            end
            else
            begin
                r.val = mag[WORD_W-1:0];
            end
        end
        else
        begin
            if (mag > NEG_LIM)
            begin
                r.flag = 1'b1;
                r.val  = ~MAX_WORD;
            end
            else
            begin
                r.val = ~mag[WORD_W-1:0] + WORD_W'(1);
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/vfa_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_sqrt: pipelined integer square root
// One root bit per stage, floor result, one radicand per cycle.
// ----------------------------------------------------------------------------
module vfa_sqrt (
    input  logic                         clk,
    input  logic [vfa_pkg::PROD_W-1:0]   radicand,
    output logic [vfa_pkg::WORD_W-1:0]   root
);
    import vfa_pkg::*;

    localparam int TRIAL_W = PROD_W + 1;

    logic [PROD_W-1:0] rem_reg  [SQ_STAGES];
    logic [PROD_W-1:0] rem_next [SQ_STAGES];
    logic [WORD_W-1:0] root_reg [SQ_STAGES];
    logic [WORD_W-1:0] root_next[SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_stage
        localparam int B = WORD_W - 1 - k;
        logic [PROD_W-1:0]  rem_in;
        logic [WORD_W-1:0]  root_in;
        logic [TRIAL_W-1:0] trial;
        logic               ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // (r + 2^b)^2 - r^2
        assign trial        = (TRIAL_W'(root_in) << (B + 1)) + (TRIAL_W'(1) << (2 * B));
        assign ge           = TRIAL_W'(rem_in) >= trial;
        assign rem_next[k]  = ge ? rem_in - trial[PROD_W-1:0] : rem_in;
        assign root_next[k] = root_in | (WORD_W'(ge) << B);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SQ_STAGES; i++)
        begin
            rem_reg[i]  <= rem_next[i];
            root_reg[i] <= root_next[i];
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

>>> hdl/vfa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_div: pipelined restoring divider
// One quotient bit per stage, truncating, one division per cycle.
// ----------------------------------------------------------------------------
module vfa_div (
    input  logic                        clk,
    input  logic [vfa_pkg::NUM_W-1:0]   num,
    input  logic [vfa_pkg::WORD_W-1:0]  den,
    input  logic                        neg,
    output logic [vfa_pkg::NUM_W-1:0]   quot,
    output logic                        quot_neg
);
    import vfa_pkg::*;

    logic [WORD_W-1:0] rem_reg [DIV_STAGES];
    logic [WORD_W-1:0] rem_next[DIV_STAGES];
    logic [NUM_W-1:0]  nq_reg  [DIV_STAGES];
    logic [NUM_W-1:0]  nq_next [DIV_STAGES];
    logic [WORD_W-1:0] den_reg [DIV_STAGES];
    logic [WORD_W-1:0] den_next[DIV_STAGES];
    logic              neg_reg [DIV_STAGES];
    logic              neg_next[DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic [WORD_W-1:0] rem_in;
        logic [NUM_W-1:0]  nq_in;
        logic [WORD_W:0]   rem2;
        logic [WORD_W:0]   diff;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign rem_in      = '0;
            assign nq_in       = num;
            assign den_next[k] = den;
            assign neg_next[k] = neg;
        end
        else
        begin : g_rest
            assign rem_in      = rem_reg[k-1];
            assign nq_in       = nq_reg[k-1];
            assign den_next[k] = den_reg[k-1];
            assign neg_next[k] = neg_reg[k-1];
        end

        assign rem2        = {rem_in, nq_in[NUM_W-1]};
        assign diff        = rem2 - {1'b0, den_next[k]};
        assign ge          = rem2 >= {1'b0, den_next[k]};
        assign rem_next[k] = ge ? diff[WORD_W-1:0] : rem2[WORD_W-1:0];
        assign nq_next[k]  = {nq_in[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            rem_reg[i] <= rem_next[i];
            nq_reg[i]  <= nq_next[i];
            den_reg[i] <= den_next[i];
            neg_reg[i] <= neg_next[i];
        end
    end

    assign quot     = nq_reg[DIV_STAGES-1];
    assign quot_neg = neg_reg[DIV_STAGES-1];

endmodule

>>> hdl/vfa_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_lane: one vector component lane
// Add/sub/scale/cross term with saturation, square for the length, and
// the component's share of divide and normalize.
// ----------------------------------------------------------------------------
module vfa_lane (
    input  logic                         clk,
    input  vfa_pkg::lane_in_t            li,
    input  vfa_pkg::den_t                dv,
    output logic [vfa_pkg::PROD_W-1:0]   sq,
    output vfa_pkg::lane_out_t           lo
);
    import vfa_pkg::*;

    typedef struct packed {
        sat_t              elem;
        logic [WORD_W-1:0] a_abs;
        logic              a_neg;
    } lane_dly_t;

    logic [CMD_W-1:0]         cmd1_reg;
    logic signed [WORD_W-1:0] a1_reg;
    logic signed [WORD_W-1:0] b1_reg;
    logic signed [PROD_W-1:0] ps1_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;
    logic [PROD_W-1:0]        sq1_reg;
    logic [WORD_W-1:0]        abs1_reg;
    logic                     neg1_reg;

    logic signed [PROD_W-1:0] ps_next;
    logic signed [PROD_W-1:0] p1_next;
    logic signed [PROD_W-1:0] p2_next;
    logic signed [PROD_W-1:0] sq_next;

    logic signed [EXT_W-1:0]  v2_reg;
    logic signed [EXT_W-1:0]  v2_next;
    logic                     shift2_reg;
    logic                     shift2_next;
    logic [WORD_W-1:0]        abs2_reg;
    logic                     neg2_reg;

    logic [EXT_W-1:0]         v_abs;
    logic [EXT_W-1:0]         v_mag;
    lane_dly_t                s3_reg;
    lane_dly_t                s3_next;
    lane_dly_t                dly_reg[LANE_DLY];
    sat_t                     elem_dly_reg[DIV_STAGES];

    logic [NUM_W-1:0]         quot;
    logic                     quot_neg;

    assign ps_next = $signed(li.a_self) * $signed(li.s);
    assign p1_next = $signed(li.a_j) * $signed(li.b_k);
    assign p2_next = $signed(li.a_k) * $signed(li.b_j);
    assign sq_next = $signed(li.a_self) * $signed(li.a_self);

    always_ff @(posedge clk)
    begin
        cmd1_reg <= li.cmd;
        a1_reg   <= li.a_self;
        b1_reg   <= li.b_self;
        ps1_reg  <= ps_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        sq1_reg  <= sq_next;
        abs1_reg <= li.a_self[WORD_W-1] ? ~li.a_self + WORD_W'(1) : li.a_self;
        neg1_reg <= li.a_self[WORD_W-1];
    end

    assign sq = sq1_reg;

    always_comb
    begin
        v2_next     = '0;
        shift2_next = 1'b0;
        unique case (cmd1_reg)
            CMD_ADD:   v2_next = EXT_W'(a1_reg) + EXT_W'(b1_reg);
            CMD_SUB:   v2_next = EXT_W'(a1_reg) - EXT_W'(b1_reg);
            CMD_SCALE:
            begin
                v2_next     = EXT_W'(ps1_reg);
                shift2_next = 1'b1;
            end
            CMD_CROSS:
            begin
                v2_next     = EXT_W'(p1_reg) - EXT_W'(p2_reg);
                shift2_next = 1'b1;
            end
            default:   v2_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        v2_reg     <= v2_next;
        shift2_reg <= shift2_next;
        abs2_reg   <= abs1_reg;
        neg2_reg   <= neg1_reg;
    end

    // truncation toward zero works on the magnitude
    assign v_abs = v2_reg[EXT_W-1] ? EXT_W'(-v2_reg) : EXT_W'(v2_reg);
    assign v_mag = shift2_reg ? (v_abs >> FRAC_W) : v_abs;

    always_comb
    begin
        s3_next.elem  = sat_sm(v2_reg[EXT_W-1], v_mag);
        s3_next.a_abs = abs2_reg;
        s3_next.a_neg = neg2_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_reg     <= s3_next;
        dly_reg[0] <= s3_reg;
        for (int i = 1; i < LANE_DLY; i++)
        begin
            dly_reg[i] <= dly_reg[i-1];
        end
        elem_dly_reg[0] <= dly_reg[LANE_DLY-1].elem;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            elem_dly_reg[i] <= elem_dly_reg[i-1];
        end
    end

    vfa_div u_div (
        .clk      (clk),
        .num      ({dly_reg[LANE_DLY-1].a_abs, {FRAC_W{1'b0}}}),
        .den      (dv.den),
        .neg      (dly_reg[LANE_DLY-1].a_neg ^ dv.den_neg),
        .quot     (quot),
        .quot_neg (quot_neg)
    );

    always_comb
    begin
        lo.elem = elem_dly_reg[DIV_STAGES-1];
        lo.quot = sat_sm(quot_neg, EXT_W'(quot));
    end

endmodule

>>> hdl/vector3_fixed_point_alu_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_top: three-component Q16.16 vector ALU
// done follows start through a valid pipeline matched to the square-root
// pipeline followed by the divider pipeline.
// Throughput: one beat per cycle; busy is always low.
// Reset clears only the valid pipeline; results are not held off.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [vfa_pkg::CMD_W-1:0]           cmd,
    input  logic signed [vfa_pkg::WORD_W-1:0]   a_x,
    input  logic signed [vfa_pkg::WORD_W-1:0]   a_y,
    input  logic signed [vfa_pkg::WORD_W-1:0]   a_z,
    input  logic signed [vfa_pkg::WORD_W-1:0]   b_x,
    input  logic signed [vfa_pkg::WORD_W-1:0]   b_y,
    input  logic signed [vfa_pkg::WORD_W-1:0]   b_z,
    input  logic signed [vfa_pkg::WORD_W-1:0]   scalar,
    output logic                                done,
    output logic signed [vfa_pkg::WORD_W-1:0]   res_x,
    output logic signed [vfa_pkg::WORD_W-1:0]   res_y,
    output logic signed [vfa_pkg::WORD_W-1:0]   res_z,
    output logic [vfa_pkg::WORD_W-2:0]          magnitude,
    output logic [vfa_pkg::STAT_W-1:0]          status
);
    import vfa_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] s_abs;
        logic              s_neg;
        logic              s_zero;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-2:0] mag;
        logic              mag_sat;
        logic              dz;
    } dctl_t;

    logic                in_vld_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [WORD_W-1:0]   a_reg[3];
    logic [WORD_W-1:0]   b_reg[3];
    logic [WORD_W-1:0]   s_reg;

    lane_in_t            li[3];
    lane_out_t           lo[3];
    logic [PROD_W-1:0]   sq[3];
    logic [PROD_W-1:0]   sum_reg;
    logic [WORD_W-1:0]   root;
    den_t                dv;

    logic [CTL_DLY-1:0]    vld_reg;
    ctl_t                  ctl_reg[CTL_DLY];
    ctl_t                  ctl_next;
    ctl_t                  ct;
    logic [DIV_STAGES-1:0] dvld_reg;
    dctl_t                 dctl_reg[DIV_STAGES];
    dctl_t                 dctl_next;
    dctl_t                 dc;

    logic                done_reg;
    logic [WORD_W-1:0]   res_reg[3];
    logic [WORD_W-1:0]   res_next[3];
    logic [WORD_W-2:0]   mag_reg;
    logic [WORD_W-2:0]   mag_next;
    logic [STAT_W-1:0]   status_reg;
    logic [STAT_W-1:0]   status_next;
    logic                elem_sat;
    logic                quot_sat;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            vld_reg    <= '0;
            dvld_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start;
            vld_reg    <= {vld_reg[CTL_DLY-2:0], in_vld_reg};
            dvld_reg   <= {dvld_reg[DIV_STAGES-2:0], vld_reg[CTL_DLY-1]};
            done_reg   <= dvld_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd;
        a_reg[0] <= a_x;
        a_reg[1] <= a_y;
        a_reg[2] <= a_z;
        b_reg[0] <= b_x;
        b_reg[1] <= b_y;
        b_reg[2] <= b_z;
        s_reg    <= scalar;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        always_comb
        begin
            li[i].cmd    = cmd_reg;
            li[i].a_self = a_reg[i];
            li[i].b_self = b_reg[i];
            li[i].a_j    = a_reg[J];
            li[i].a_k    = a_reg[K];
            li[i].b_j    = b_reg[J];
            li[i].b_k    = b_reg[K];
            li[i].s      = s_reg;
        end

        vfa_lane u_lane (
            .clk (clk),
            .li  (li[i]),
            .dv  (dv),
            .sq  (sq[i]),
            .lo  (lo[i])
        );
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sq[0] + sq[1] + sq[2];
    end

    vfa_sqrt u_sqrt (
        .clk      (clk),
        .radicand (sum_reg),
        .root     (root)
    );

    always_comb
    begin
        ctl_next.cmd    = cmd_reg;
        ctl_next.s_abs  = s_reg[WORD_W-1] ? ~s_reg + WORD_W'(1) : s_reg;
        ctl_next.s_neg  = s_reg[WORD_W-1];
        ctl_next.s_zero = (s_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        ctl_reg[0] <= ctl_next;
        for (int i = 1; i < CTL_DLY; i++)
        begin
            ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    assign ct = ctl_reg[CTL_DLY-1];

    // divisor select: scalar for divide, length for normalize
    always_comb
    begin
        dv.den          = (ct.cmd == CMD_DIV) ? ct.s_abs : root;
        dv.den_neg      = (ct.cmd == CMD_DIV) && ct.s_neg;
        dctl_next.cmd   = ct.cmd;
        dctl_next.mag_sat = root > MAX_WORD;
        dctl_next.mag   = (root > MAX_WORD) ? MAX_WORD[WORD_W-2:0] : root[WORD_W-2:0];
        dctl_next.dz    = ((ct.cmd == CMD_DIV) && ct.s_zero) ||
                          ((ct.cmd == CMD_NORM) && (root == '0));
    end

    always_ff @(posedge clk)
    begin
        dctl_reg[0] <= dctl_next;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            dctl_reg[i] <= dctl_reg[i-1];
        end
    end

    assign dc       = dctl_reg[DIV_STAGES-1];
    assign elem_sat = lo[0].elem.flag | lo[1].elem.flag | lo[2].elem.flag;
    assign quot_sat = lo[0].quot.flag | lo[1].quot.flag | lo[2].quot.flag;

    // merge lanes into one result beat
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            res_next[i] = '0;
        end
        mag_next    = '0;
        status_next = ST_OK;
        unique case (dc.cmd)
            CMD_ADD, CMD_SUB, CMD_SCALE, CMD_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    res_next[i] = lo[i].elem.val;
                end
                status_next = elem_sat ? ST_SAT : ST_OK;
            end
            CMD_DIV:
            begin
                if (dc.dz)
                begin
                    status_next = ST_DZ;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        res_next[i] = lo[i].quot.val;
                    end
                    status_next = quot_sat ? ST_SAT : ST_OK;
                end
            end
            CMD_LEN:
            begin
                mag_next    = dc.mag;
                status_next = dc.mag_sat ? ST_SAT : ST_OK;
            end
            CMD_NORM:
            begin
                if (dc.dz)
                begin
                    status_next = ST_DZ;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        res_next[i] = lo[i].quot.val;
                    end
                    mag_next    = dc.mag;
                    status_next = (dc.mag_sat || quot_sat) ? ST_SAT : ST_OK;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            res_reg[i] <= res_next[i];
        end
        mag_reg    <= mag_next;
        status_reg <= status_next;
    end

    assign done      = done_reg;
    assign res_x     = res_reg[0];
    assign res_y     = res_reg[1];
    assign res_z     = res_reg[2];
    assign magnitude = mag_reg;
    assign status    = status_reg;

endmodule

>>> sim/vector3_fixed_point_alu_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_top_tb: self-checking bench for the Q16.16 vector ALU
// A directed set covers the field extremes, every opcode, divide by zero,
// normalizing the zero vector and saturation. Random beats follow under
// several start-idling patterns. Each accepted beat is run through an
// in-bench predictor and the done beats are checked in order, field by field.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_top_tb;
    import vfa_pkg::*;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] ax, ay, az, bx, by, bz, s;
    } vec_cmd_t;

    typedef struct {
        logic [WORD_W-1:0] rx, ry, rz;
        logic [WORD_W-2:0] mag;
        logic [STAT_W-1:0] st;
    } vec_res_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [CMD_W-1:0] cmd;
    logic signed [WORD_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z, scalar;
    logic done;
    logic signed [WORD_W-1:0] res_x, res_y, res_z;
    logic [WORD_W-2:0] magnitude;
    logic [STAT_W-1:0] status;

    vec_res_t expected_results[$];
    int errors;
    int beats_sent;
    int beats_checked;
    int idle_pct;
    int quiet_cycles;
    int op_seen[8];

    vector3_fixed_point_alu_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .scalar(scalar), .done(done), .res_x(res_x), .res_y(res_y),
        .res_z(res_z), .magnitude(magnitude), .status(status)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [32:0] abs33(input logic [WORD_W-1:0] v);
        logic signed [32:0] e;
        e = $signed(v);
        return (e < 0) ? 33'(-e) : 33'(e);
    endfunction

    function automatic logic [WORD_W-1:0] sat_word(input bit neg, input logic [65:0] mag,
                                                  inout bit flag);
        if (!neg)
        begin
            if (mag > 66'h7FFF_FFFF)
            begin
                flag = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return mag[31:0];
        end
        if (mag > 66'h8000_0000)
        begin
            flag = 1'b1;
            return 32'h8000_0000;
        end
        return 32'(-mag[31:0]);
    endfunction

    function automatic logic [WORD_W-1:0] signed_sat(input logic signed [65:0] v,
                                                    input int shift, inout bit flag);
        logic [65:0] m;
        m = (v < 0) ? 66'(-v) : 66'(v);
        m = m >> shift;
        return sat_word(v < 0, m, flag);
    endfunction

    function automatic logic [WORD_W-1:0] fix_div(input logic [WORD_W-1:0] a,
                                                 input logic [65:0] d, input bit dneg,
                                                 inout bit flag);
        logic [65:0] q;
        q = ({33'd0, abs33(a)} << FRAC_W) / d;
        return sat_word(a[31] != dneg, q, flag);
    endfunction

    function automatic vec_res_t compute_vector_op(input vec_cmd_t c);
        vec_res_t r;
        logic [WORD_W-1:0] av[3];
        logic [WORD_W-1:0] bv[3];
        logic signed [65:0] ea, eb, es, p1, p2;
        logic [65:0] sumsq, cand, len;
        bit satf;
        bit dz;
        int j;
        int k;
        av[0] = c.ax; av[1] = c.ay; av[2] = c.az;
        bv[0] = c.bx; bv[1] = c.by; bv[2] = c.bz;
        r.rx = '0; r.ry = '0; r.rz = '0; r.mag = '0; r.st = ST_OK;
        satf = 1'b0;
        dz = 1'b0;
        es = $signed(c.s);
        for (int i = 0; i < 3; i++)
        begin
            logic [WORD_W-1:0] v;
            ea = $signed(av[i]);
            eb = $signed(bv[i]);
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            v = '0;
            case (c.cmd)
                CMD_ADD:   v = signed_sat(ea + eb, 0, satf);
                CMD_SUB:   v = signed_sat(ea - eb, 0, satf);
                CMD_SCALE: v = signed_sat(ea * es, FRAC_W, satf);
                CMD_DIV:
                begin
                    if (es == 0)
                        dz = 1'b1;
                    else
                        v = fix_div(av[i], {33'd0, abs33(c.s)}, c.s[31], satf);
                end
                CMD_CROSS:
                begin
                    p1 = 66'($signed(av[j])) * 66'($signed(bv[k]));
                    p2 = 66'($signed(av[k])) * 66'($signed(bv[j]));
                    v = signed_sat(p1 - p2, FRAC_W, satf);
                end
                default: v = '0;
            endcase
            if (i == 0) r.rx = v;
            if (i == 1) r.ry = v;
            if (i == 2) r.rz = v;
        end
        if (c.cmd == CMD_LEN || c.cmd == CMD_NORM)
        begin
            sumsq = '0;
            for (int i = 0; i < 3; i++)
                sumsq = sumsq + {33'd0, abs33(av[i])} * {33'd0, abs33(av[i])};
            // sum of squares is below 2^64, so the root fits in 32 bits
            len = '0;
            for (int b = 31; b >= 0; b--)
            begin
                cand = len | (66'd1 << b);
                if (cand * cand <= sumsq)
                    len = cand;
            end
            if (len > 66'h7FFF_FFFF)
            begin
                r.mag = 31'h7FFF_FFFF;
                satf = 1'b1;
            end
            else
                r.mag = len[30:0];
            if (c.cmd == CMD_NORM)
            begin
                if (len == 0)
                    dz = 1'b1;
                else
                begin
                    r.rx = fix_div(c.ax, len, 1'b0, satf);
                    r.ry = fix_div(c.ay, len, 1'b0, satf);
                    r.rz = fix_div(c.az, len, 1'b0, satf);
                end
            end
        end
        if (dz)
        begin
            r.rx = '0; r.ry = '0; r.rz = '0; r.mag = '0; r.st = ST_DZ;
        end
        else if (satf)
            r.st = ST_SAT;
        return r;
    endfunction

    // accept and result monitors; values read here are the pre-edge ones
    always @(posedge clk)
    begin
        vec_cmd_t c;
        vec_res_t e;
        bit active;
        if (rst_n)
        begin
            active = 1'b0;
            if (start && !busy)
            begin
                c.cmd = cmd; c.ax = a_x; c.ay = a_y; c.az = a_z;
                c.bx = b_x; c.by = b_y; c.bz = b_z; c.s = scalar;
                expected_results.push_back(compute_vector_op(c));
                op_seen[cmd] <= op_seen[cmd] + 1;
                active = 1'b1;
            end
            if (done)
            begin
                active = 1'b1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat x=%h y=%h z=%h mag=%h st=%0d",
                             $time, res_x, res_y, res_z, magnitude, status);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    beats_checked <= beats_checked + 1;
                    if (res_x !== e.rx || res_y !== e.ry || res_z !== e.rz ||
                        magnitude !== e.mag || status !== e.st)
                    begin
                        $display("%0t: mismatch exp x=%h y=%h z=%h mag=%h st=%0d", $time,
                                 e.rx, e.ry, e.rz, e.mag, e.st);
                        $display("%0t:          act x=%h y=%h z=%h mag=%h st=%0d", $time,
                                 res_x, res_y, res_z, magnitude, status);
                        errors <= errors + 1;
                    end
                end
            end
            quiet_cycles <= active ? 0 : quiet_cycles + 1;
            if (quiet_cycles > 5000)
            begin
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         expected_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_beat(input vec_cmd_t c);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c.cmd; a_x <= c.ax; a_y <= c.ay; a_z <= c.az;
        b_x <= c.bx; b_y <= c.by; b_z <= c.bz; scalar <= c.s;
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
            2: return 32'($signed($urandom_range(0, 2 ** 26)) - 2 ** 25);
            3:
            begin
                case ($urandom_range(4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0001_0000;
                    3: return 32'hFFFF_0000;
                    default: return '0;
                endcase
            end
            default: return 32'($signed($urandom_range(0, 2 ** 23)) - 2 ** 22);
        endcase
    endfunction

    function automatic vec_cmd_t mk_cmd(input logic [CMD_W-1:0] op,
                                        input logic [WORD_W-1:0] ax, ay, az, bx, by, bz, s);
        vec_cmd_t c;
        c.cmd = op; c.ax = ax; c.ay = ay; c.az = az;
        c.bx = bx; c.by = by; c.bz = bz; c.s = s;
        return c;
    endfunction

    task automatic test_directed();
        localparam logic [WORD_W-1:0] MX = 32'h7FFF_FFFF;
        localparam logic [WORD_W-1:0] MN = 32'h8000_0000;
        localparam logic [WORD_W-1:0] ONE = 32'h0001_0000;
        idle_pct = 0;
        send_beat(mk_cmd(CMD_ADD, ONE, 32'h0002_8000, MN, ONE, 32'hFFFF_0000, MN, 0));
        send_beat(mk_cmd(CMD_ADD, MX, MX, 0, MX, 1, 0, 0));
        send_beat(mk_cmd(CMD_SUB, MN, MX, 5, MX, MN, 7, 0));
        send_beat(mk_cmd(CMD_SUB, MN, 0, 0, 0, MN, 0, MX));
        send_beat(mk_cmd(CMD_SCALE, ONE, 32'hFFFF_8000, 3, 0, 0, 0, 32'h0002_0000));
        send_beat(mk_cmd(CMD_SCALE, MX, MN, MN, 0, 0, 0, MN));
        send_beat(mk_cmd(CMD_SCALE, 1, 32'hFFFF_FFFF, MX, 0, 0, 0, 32'h0000_8000));
        send_beat(mk_cmd(CMD_DIV, ONE, 32'hFFFD_0000, 7, 0, 0, 0, 32'h0003_0000));
        send_beat(mk_cmd(CMD_DIV, ONE, ONE, ONE, 0, 0, 0, 0));
        send_beat(mk_cmd(CMD_DIV, MX, MN, 1, 0, 0, 0, 1));
        send_beat(mk_cmd(CMD_DIV, MN, MX, 32'hFFFF_FFF9, 0, 0, 0, MN));
        send_beat(mk_cmd(CMD_DIV, MN, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_beat(mk_cmd(CMD_CROSS, ONE, 0, 0, 0, ONE, 0, 0));
        send_beat(mk_cmd(CMD_CROSS, MX, MN, MX, MN, MX, MN, 0));
        send_beat(mk_cmd(CMD_CROSS, MN, MN, MN, MX, MN, MX, 0));
        send_beat(mk_cmd(CMD_LEN, 32'h0003_0000, 32'h0004_0000, 0, MX, MX, MX, MX));
        send_beat(mk_cmd(CMD_LEN, MN, MN, MN, 0, 0, 0, 0));
        send_beat(mk_cmd(CMD_LEN, 0, 0, 0, 1, 1, 1, 1));
        send_beat(mk_cmd(CMD_NORM, 0, 0, 0, MX, MX, MX, MX));
        send_beat(mk_cmd(CMD_NORM, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0, 0, 0));
        send_beat(mk_cmd(CMD_NORM, 1, 0, 0, 0, 0, 0, 0));
        send_beat(mk_cmd(CMD_NORM, MN, MX, 1, 0, 0, 0, 0));
        send_beat(mk_cmd(3'd7, MX, MN, ONE, MX, MN, ONE, MX));
        send_beat(mk_cmd(3'd7, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random(input int pct, input int count);
        vec_cmd_t c;
        idle_pct = pct;
        for (int n = 0; n < count; n++)
        begin
            c.cmd = $urandom_range(0, 15) == 0 ? 3'd7 : 3'($urandom_range(0, 6));
            c.ax = rand_word(); c.ay = rand_word(); c.az = rand_word();
            c.bx = rand_word(); c.by = rand_word(); c.bz = rand_word();
            c.s = rand_word();
            if ($urandom_range(19) == 0)
                c.s = '0;
            if ((c.cmd == CMD_NORM || c.cmd == CMD_LEN) && $urandom_range(19) == 0)
            begin
                c.ax = '0; c.ay = '0; c.az = '0;
            end
            send_beat(c);
        end
    endtask

    initial
    begin
        errors = 0;
        beats_sent = 0;
        beats_checked = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        foreach (op_seen[i]) op_seen[i] = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= '0; a_x <= '0; a_y <= '0; a_z <= '0;
        b_x <= '0; b_y <= '0; b_z <= '0; scalar <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(0, 300);
        test_random(51, 300);
        test_random(26, 300);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        $display("Run covered %0d beats, %0d results checked, %0d errors.",
                 beats_sent, beats_checked, errors);
        $display("Per opcode add..7: %0d %0d %0d %0d %0d %0d %0d %0d", op_seen[0],
                 op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
                 op_seen[6], op_seen[7]);
        if (errors == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> files.f
hdl/vfa_pkg.sv
hdl/vfa_sqrt.sv
hdl/vfa_div.sv
hdl/vfa_lane.sv
hdl/vector3_fixed_point_alu_top.sv
sim/vector3_fixed_point_alu_top_tb.sv
